// File: hdl/lru_fully_associative_cache_defines.svh
// ---------------------------------------------------------------------------
// lru cache assertion macros
// shared assertion helpers for the cache checker
// ---------------------------------------------------------------------------
`ifndef LRU_FULLY_ASSOCIATIVE_CACHE_DEFINES_SVH
`define LRU_FULLY_ASSOCIATIVE_CACHE_DEFINES_SVH

// plain property, sampled on clk, off while rst_n is low
`define LRUFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// something that must hold in the cycle after a stalled result
`define LRUFA_ASSERT_STALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (out_tvalid && !out_tready) |=> prop) else $error(msg);

`endif

// File: hdl/lrufa_pkg.sv
// ---------------------------------------------------------------------------
// lru cache package
// command codes, field widths and stream packing offsets
// ---------------------------------------------------------------------------
package lrufa_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

  // input stream packing
  localparam int IN_TDATA_W = 48;
  localparam int IN_TUSER_W = 2;
  localparam int KEY_LSB    = 0;
  localparam int VAL_LSB    = 16;

  // result stream packing
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 2;
  localparam int RD_LSB      = 0;
  localparam int EVK_LSB     = 32;
  localparam int HTOT_LSB    = 48;
  localparam int MTOT_LSB    = 80;
  localparam int HIT_BIT     = 0;
  localparam int EVICT_BIT   = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

endpackage

// File: hdl/lru_fully_associative_cache.sv
// path: each item passes the input register, then the result register
// throughput: one item per cycle while out_tready does not stall the result; the parallel
//   key compare and rank update between the two registers set the cycle time
// reset: synchronous active-low rst_n empties the store, zeroes the counters and
//   sets capacity back to 10; key and data entries are not cleared
// ---------------------------------------------------------------------------
// lru fully associative cache
// key/value store with lookup, load and clear commands and lru replacement
// ---------------------------------------------------------------------------
module lru_fully_associative_cache #(
  parameter int MAX_ENTRIES = lrufa_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_WIDTH   = lrufa_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH  = lrufa_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lrufa_pkg::IN_TDATA_W-1:0]   in_tdata,   // key[15:0], value[47:16]
  input  logic [lrufa_pkg::IN_TUSER_W-1:0]   in_tuser,   // cmd[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lrufa_pkg::OUT_TDATA_W-1:0]  out_tdata,  // read_data[31:0], evicted_key[47:32],
                                                         // hit_total[79:48], miss_total[111:80]
  output logic [lrufa_pkg::OUT_TUSER_W-1:0]  out_tuser,  // hit[0], evicted[1]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrufa_pkg::CAP_W-1:0]        cfg_data
);

  localparam int FW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CAPW  = lrufa_pkg::CAP_W;
  localparam int CMP_W = (FW > CAPW) ? FW : CAPW;
  localparam int KW_O  = lrufa_pkg::KEY_W;
  localparam int DW_O  = lrufa_pkg::VALUE_W;
  localparam int CW    = lrufa_pkg::CNT_W;

  // configuration
  logic [CAPW-1:0] cap_r;

  // input register
  logic                  in_vld_r;
  lrufa_pkg::cmd_t       cmd_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] val_r;

  // store
  logic [KEY_WIDTH-1:0]  keys_r [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] data_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [AW-1:0]          age_r   [MAX_ENTRIES];
  logic [AW-1:0]          age_nxt [MAX_ENTRIES];
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          hit_cnt_r, hit_cnt_nxt;
  logic [CW-1:0]          miss_cnt_r, miss_cnt_nxt;

  // lookup and replacement selection
  logic [MAX_ENTRIES-1:0] match, victim, free_sel, ins_sel;
  logic [MAX_ENTRIES-1:0] key_we, data_we;
  logic                   hit_any;
  logic [AW-1:0]          hit_rank, last_rank;
  logic [DATA_WIDTH-1:0]  hit_data;
  logic [KEY_WIDTH-1:0]   vic_key;
  logic [CMP_W-1:0]       cap_eff;
  logic                   full;

  // result register
  logic            out_vld_r;
  logic            hit_o_r, hit_o_nxt;
  logic            evict_o_r, evict_o_nxt;
  logic [DW_O-1:0] rd_o_r, rd_o_nxt;
  logic [KW_O-1:0] evk_o_r, evk_o_nxt;

  logic step;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrufa_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= lrufa_pkg::cmd_t'(in_tuser[lrufa_pkg::CMD_W-1:0]);
      key_r <= KEY_WIDTH'(in_tdata[lrufa_pkg::KEY_LSB +: KW_O]);
      val_r <= DATA_WIDTH'(in_tdata[lrufa_pkg::VAL_LSB +: DW_O]);
    end
  end

  // match, lru victim and lowest free slot
  always_comb begin
    last_rank = AW'(fill_r - FW'(1));
    hit_rank  = '0;
    hit_data  = '0;
    vic_key   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid_r[i] && (keys_r[i] == key_r);
      victim[i] = valid_r[i] && (age_r[i] == last_rank);
      if (match[i]) begin
        hit_rank = hit_rank | age_r[i];
        hit_data = hit_data | data_r[i];
      end
      if (victim[i]) begin
        vic_key = vic_key | keys_r[i];
      end
    end
    hit_any  = |match;
    free_sel = ~valid_r & (valid_r + MAX_ENTRIES'(1));

    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
    full    = CMP_W'(fill_r) >= cap_eff;
    ins_sel = full ? victim : free_sel;
  end

  // next state and result
  always_comb begin
    valid_nxt    = valid_r;
    age_nxt      = age_r;
    fill_nxt     = fill_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    key_we       = '0;
    data_we      = '0;
    hit_o_nxt    = 1'b0;
    evict_o_nxt  = 1'b0;
    rd_o_nxt     = '0;
    evk_o_nxt    = '0;

    case (cmd_r)
      lrufa_pkg::CMD_LOOKUP, lrufa_pkg::CMD_LOAD: begin
        if (hit_any) begin
          // touch: younger entries age by one, hit entry becomes newest
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match[i]) begin
              age_nxt[i] = '0;
            end else if (valid_r[i] && (age_r[i] < hit_rank)) begin
              age_nxt[i] = age_r[i] + AW'(1);
            end
          end
          hit_o_nxt = 1'b1;
          if (cmd_r == lrufa_pkg::CMD_LOOKUP) begin
            rd_o_nxt    = DW_O'(hit_data);
            hit_cnt_nxt = hit_cnt_r + CW'(1);
          end else begin
            data_we = match;
          end
        end else if (cmd_r == lrufa_pkg::CMD_LOOKUP) begin
          miss_cnt_nxt = miss_cnt_r + CW'(1);
        end else begin
          // new key: replace the lru entry when full, else take a free slot
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (ins_sel[i]) begin
              age_nxt[i]   = '0;
              valid_nxt[i] = 1'b1;
            end else if (valid_r[i]) begin
              age_nxt[i] = age_r[i] + AW'(1);
            end
          end
          key_we  = ins_sel;
          data_we = ins_sel;
          if (full) begin
            evict_o_nxt = 1'b1;
            evk_o_nxt   = KW_O'(vic_key);
          end else begin
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      lrufa_pkg::CMD_CLEAR: begin
        valid_nxt    = '0;
        fill_nxt     = '0;
        hit_cnt_nxt  = '0;
        miss_cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (step) begin
      valid_r    <= valid_nxt;
      fill_r     <= fill_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      age_r      <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (key_we[i]) begin
          keys_r[i] <= key_r;
        end
        if (data_we[i]) begin
          data_r[i] <= val_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hit_o_r   <= hit_o_nxt;
      evict_o_r <= evict_o_nxt;
      rd_o_r    <= rd_o_nxt;
      evk_o_r   <= evk_o_nxt;
    end
  end

  // counters are shown after the step, taken from their next values
  logic [CW-1:0] htot_o_r, mtot_o_r;

  always_ff @(posedge clk) begin
    if (step) begin
      htot_o_r <= hit_cnt_nxt;
      mtot_o_r <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {mtot_o_r, htot_o_r, evk_o_r, rd_o_r};
  assign out_tuser  = {evict_o_r, hit_o_r};

endmodule

// File: hdl/lrufa_checker.sv
// ---------------------------------------------------------------------------
// lru cache port checker
// watches the result stream of the cache, attached by bind
// ---------------------------------------------------------------------------
`include "lru_fully_associative_cache_defines.svh"

module lrufa_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [lrufa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [lrufa_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  `LRUFA_ASSERT_STALL(a_valid_held, out_tvalid, "result item dropped while stalled")

  `LRUFA_ASSERT_STALL(a_payload_held, $stable(out_tdata) && $stable(out_tuser), "stalled result item changed")

  // a load that finds its key never evicts
  `LRUFA_ASSERT(a_hit_no_evict, out_tvalid |-> !(out_tuser[lrufa_pkg::HIT_BIT] && out_tuser[lrufa_pkg::EVICT_BIT]), "hit and eviction in one item")

  `LRUFA_ASSERT(a_evk_zero, (out_tvalid && !out_tuser[lrufa_pkg::EVICT_BIT]) |-> (out_tdata[lrufa_pkg::HTOT_LSB-1:lrufa_pkg::EVK_LSB] == '0), "evicted key set without eviction")

  // eviction only comes from a load, which returns no data
  `LRUFA_ASSERT(a_evict_no_data, (out_tvalid && out_tuser[lrufa_pkg::EVICT_BIT]) |-> (out_tdata[lrufa_pkg::EVK_LSB-1:lrufa_pkg::RD_LSB] == '0), "read data on an evicting load")

endmodule

bind lru_fully_associative_cache lrufa_checker u_lrufa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: test/lru_fully_associative_cache_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru cache testbench
// drives lookup, load, clear and unused commands through the input stream,
// mirrors the lru store in a scoreboard and checks every result field by
// field; capacity is rewritten between idle phases, including out of range
// ---------------------------------------------------------------------------
module lru_fully_associative_cache_tb;

  localparam int MAX_ENTRIES_DEF = lrufa_pkg::MAX_ENTRIES_DEF;
  localparam int CMD_W           = lrufa_pkg::CMD_W;
  localparam int KEY_W           = lrufa_pkg::KEY_W;
  localparam int VALUE_W         = lrufa_pkg::VALUE_W;
  localparam int CAP_W           = lrufa_pkg::CAP_W;
  localparam int CNT_W           = lrufa_pkg::CNT_W;
  localparam int IN_TDATA_W      = lrufa_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W      = lrufa_pkg::IN_TUSER_W;
  localparam int OUT_TDATA_W     = lrufa_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W     = lrufa_pkg::OUT_TUSER_W;
  localparam int RD_LSB          = lrufa_pkg::RD_LSB;
  localparam int EVK_LSB         = lrufa_pkg::EVK_LSB;
  localparam int HTOT_LSB        = lrufa_pkg::HTOT_LSB;
  localparam int MTOT_LSB        = lrufa_pkg::MTOT_LSB;
  localparam int HIT_BIT         = lrufa_pkg::HIT_BIT;
  localparam int EVICT_BIT       = lrufa_pkg::EVICT_BIT;

  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 65;
  localparam int POOL_SIZE    = 24;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic               hit;
    logic [VALUE_W-1:0] read_data;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
  } cache_response_t;

  class lru_cache_scoreboard;
    logic [KEY_W-1:0]   entry_key  [MAX_ENTRIES_DEF];
    logic [VALUE_W-1:0] entry_word [MAX_ENTRIES_DEF];
    bit                 entry_used [MAX_ENTRIES_DEF];
    int unsigned        entry_age  [MAX_ENTRIES_DEF];
    int unsigned        fill;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [CAP_W-1:0]   capacity;
    cache_response_t    expected_responses[$];
    int                 mismatch_count;
    int                 response_count;

    function new();
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
        entry_key[i]  = '0;
        entry_word[i] = '0;
        entry_used[i] = 1'b0;
        entry_age[i]  = 0;
      end
      fill           = 0;
      hits           = '0;
      misses         = '0;
      capacity       = lrufa_pkg::CAPACITY_RESET;
      mismatch_count = 0;
      response_count = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        if (entry_used[i] && entry_key[i] == key) return i;
      return -1;
    endfunction

    // entries younger than the touched one age by one
    function void make_newest(int slot);
      int unsigned age;
      age = entry_age[slot];
      for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        if (entry_used[i] && i != slot && entry_age[i] < age) entry_age[i]++;
      entry_age[slot] = 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value);
      cache_response_t resp;
      int              slot;
      int unsigned     limit;
      resp = '{1'b0, '0, 1'b0, '0, '0, '0};
      if (cmd == lrufa_pkg::CMD_LOOKUP) begin
        slot = find_slot(key);
        if (slot >= 0) begin
          make_newest(slot);
          resp.hit       = 1'b1;
          resp.read_data = entry_word[slot];
          hits++;
        end else begin
          misses++;
        end
      end else if (cmd == lrufa_pkg::CMD_LOAD) begin
        slot = find_slot(key);
        if (slot >= 0) begin
          entry_word[slot] = value;
          make_newest(slot);
          resp.hit = 1'b1;
        end else begin
          limit = (capacity == 0) ? 1 :
                  (capacity > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(capacity);
          if (fill >= limit) begin
            for (int i = 0; i < MAX_ENTRIES_DEF; i++)
              if (entry_used[i] && (slot < 0 || entry_age[i] > entry_age[slot])) slot = i;
            if (slot >= 0) begin
              resp.evicted     = 1'b1;
              resp.evicted_key = entry_key[slot];
              entry_used[slot] = 1'b0;
              fill--;
            end
          end
          // free slot: lowest-numbered unused entry
          for (int i = 0; i < MAX_ENTRIES_DEF && slot < 0; i++)
            if (!entry_used[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < MAX_ENTRIES_DEF; i++)
              if (entry_used[i]) entry_age[i]++;
            entry_key[slot]  = key;
            entry_word[slot] = value;
            entry_used[slot] = 1'b1;
            entry_age[slot]  = 0;
            fill++;
          end
        end
      end else if (cmd == lrufa_pkg::CMD_CLEAR) begin
        for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
          entry_used[i] = 1'b0;
          entry_age[i]  = 0;
        end
        fill   = 0;
        hits   = '0;
        misses = '0;
      end
      resp.hit_total  = hits;
      resp.miss_total = misses;
      expected_responses.insert(expected_responses.size(), resp);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t: result %0d %s: got 0x%08h, expected 0x%08h",
               $time, response_count, field, got, want);
    endtask

    task check_response(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      cache_response_t want;
      response_count++;
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected item", tdata[31:0], '0);
        return;
      end
      want = expected_responses[0];
      expected_responses.delete(0);
      if (tuser[HIT_BIT] !== want.hit)
        report_mismatch("hit", 32'(tuser[HIT_BIT]), 32'(want.hit));
      if (tdata[RD_LSB +: VALUE_W] !== want.read_data)
        report_mismatch("read_data", tdata[RD_LSB +: VALUE_W], want.read_data);
      if (tuser[EVICT_BIT] !== want.evicted)
        report_mismatch("evicted", 32'(tuser[EVICT_BIT]), 32'(want.evicted));
      if (tdata[EVK_LSB +: KEY_W] !== want.evicted_key)
        report_mismatch("evicted_key", 32'(tdata[EVK_LSB +: KEY_W]), 32'(want.evicted_key));
      if (tdata[HTOT_LSB +: CNT_W] !== want.hit_total)
        report_mismatch("hit_total", tdata[HTOT_LSB +: CNT_W], want.hit_total);
      if (tdata[MTOT_LSB +: CNT_W] !== want.miss_total)
        report_mismatch("miss_total", tdata[MTOT_LSB +: CNT_W], want.miss_total);
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // key[15:0], value[47:16]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;   // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // read_data, evicted_key, hit_total, miss_total
  logic [OUT_TUSER_W-1:0] out_tuser;         // hit[0], evicted[1]
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data   = '0;

  lru_cache_scoreboard sb = new();
  bit                  src_idle_en = 1'b1;
  bit                  snk_idle_en = 1'b1;
  int                  hold_cycles = 0;
  logic [KEY_W-1:0]    key_pool[POOL_SIZE];

  lru_fully_associative_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // valid stays high after an accept so back-to-back items need no reassignment
  task send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, key, value);
  endtask

  task drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(cap);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task run_random_phase(logic [CAP_W-1:0] cap, int count);
    int               span;
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    span = (cap == 0) ? 1 : (cap > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cap);
    span = (span + 4 > POOL_SIZE) ? POOL_SIZE : span + 4;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      cmd  = (pick < 45) ? lrufa_pkg::CMD_LOOKUP : (pick < 95) ? lrufa_pkg::CMD_LOAD :
             (pick < 97) ? lrufa_pkg::CMD_CLEAR : CMD_UNUSED;
      // mostly a small key set so lookups hit and loads evict
      if ($urandom_range(0, 4) == 0) key = KEY_W'($urandom);
      else                           key = key_pool[$urandom_range(0, span - 1)];
      send_request(cmd, key, $urandom);
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else begin
        stall = snk_idle_en ? $urandom_range(0, 17) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_response(out_tdata, out_tuser);
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps[NUM_PHASES];
    phase_caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd10, 5'd0, 5'd17, 5'd7, 5'd2, 5'd12};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset capacity: empty miss, extremes, update, unused command, clear
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h0000, 32'h0000_0000);
    send_request(lrufa_pkg::CMD_LOAD,   16'h0000, 32'h0000_0000);
    send_request(lrufa_pkg::CMD_LOAD,   16'hFFFF, 32'hFFFF_FFFF);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED,            16'hFFFF, 32'hFFFF_FFFF);
    send_request(lrufa_pkg::CMD_LOAD,   16'h0000, 32'h5A5A_5A5A);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h0000, 32'h0000_0000);
    send_request(lrufa_pkg::CMD_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
    drain_results();

    // two entries: lookup refreshes age, next new key evicts the oldest
    write_capacity(5'd2);
    send_request(lrufa_pkg::CMD_LOAD,   16'h1234, 32'hA5A5_A5A5);
    send_request(lrufa_pkg::CMD_LOAD,   16'h00FF, 32'h0000_0001);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h1234, 32'h0000_0000);
    send_request(lrufa_pkg::CMD_LOAD,   16'h0F0F, 32'h0000_0002);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h00FF, 32'h0000_0000);
    drain_results();

    // zero capacity behaves as one entry
    write_capacity(5'd0);
    send_request(lrufa_pkg::CMD_LOAD,   16'hAAAA, 32'h0000_0003);
    send_request(lrufa_pkg::CMD_LOAD,   16'h5555, 32'h0000_0004);
    send_request(lrufa_pkg::CMD_LOOKUP, 16'h5555, 32'h0000_0000);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      src_idle_en = (p % 3 != 1);
      snk_idle_en = (p % 4 != 2);
      // long receiver hold while the sender streams, so the input backs up
      if (p == 0 || p == 6) begin
        src_idle_en = 1'b0;
        hold_cycles = 120;
      end
      run_random_phase(phase_caps[p], PHASE_ITEMS);
      drain_results();
    end

    if (sb.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
